/* rtl/core/sha256_pkg.sv */
// Package for the SHA-256 byte stream hasher: types, constants and round functions.
// Used by the controller, datapath and top level; depends on nothing.
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned LenPos     = 56;

  typedef logic [31:0] word_t;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte = 8'h80;

  // Controller states.
  typedef enum logic [2:0] {
    StIdle,      // accepting bytes
    StCompress,  // running rounds on a full block
    StPadFill,   // writing padding bytes into the block
    StPadComp,   // rounds on a padding block
    StEmit       // handing out digest words
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       absorb;     // store input byte, bump count
    logic       pad_write;  // store one padding byte at fill position
    logic       pad_first;  // this padding byte is 0x80
    logic       pad_len;    // this padding block carries the bit length
    logic       comp_start; // load working vars, round 0 next
    logic       round_en;   // run one round
    logic       comp_done;  // fold working vars into hash
    logic       out_next;   // advance digest word pointer
    logic       restart;    // back to initial values
  } cmd_t;

  // Status back to controller.
  typedef struct packed {
    logic       fill_wrap;   // fill at 63, the next byte completes the block
    logic       len_zone;    // fill at or above 56 (length bytes)
    logic       round_last;
    logic       out_last;
  } stat_t;

  function automatic word_t rotr(word_t x, int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bsig0(word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t ssig0(word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

/* rtl/core/sha256_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependence.
module sha256_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/sha256_datapath.sv */
// Datapath of the SHA-256 hasher: block buffer, counters, schedule and round logic.
// Depends on sha256_pkg and sha256_ram.
module sha256_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha256_pkg::cmd_t   cmd_i,
  output sha256_pkg::stat_t  stat_o,
  input  logic [7:0]         message_byte_i,
  output logic [31:0]        digest_word_o,
  output logic [2:0]         word_index_o
);
  import sha256_pkg::*;

  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  word_t       hash_q [8];
  word_t       v_q [8];
  word_t       w_q [16];
  logic [5:0]  rnd_q;
  logic [2:0]  oidx_q;
  // Read pointer runs four bytes per word; one byte per cycle is not enough
  // for a round per cycle, so the block is held in four byte-lane RAMs.
  logic [3:0]  rd_word;
  logic [7:0]  lane_rd [4];
  logic [7:0]  wbyte;
  logic [1:0]  wlane;
  logic        we;

  assign wlane = fill_q[1:0];
  assign we    = cmd_i.absorb | cmd_i.pad_write;

  // Length bytes go out most significant first: position 56 takes bits 63:56.
  always_comb begin
    if (cmd_i.absorb) begin
      wbyte = message_byte_i;
    end else if (cmd_i.pad_first) begin
      wbyte = PadByte;
    end else if (cmd_i.pad_len && (fill_q >= 6'(LenPos))) begin
      wbyte = bits_q[{~fill_q[2:0], 3'b111} -: 8];
    end else begin
      wbyte = 8'h00;
    end
  end

  // Word address read ahead: at comp_start word 0, then the round number + 1.
  assign rd_word = cmd_i.comp_start ? 4'd0 : 4'(rnd_q + 6'd1);

  for (genvar l = 0; l < 4; l++) begin : g_lane
    sha256_ram #(.Width(8), .Depth(BlockBytes / 4)) u_ram (
      .clk_i   (clk_i),
      .we_i    (we && (wlane == 2'(l))),
      .waddr_i (fill_q[5:2]),
      .wdata_i (wbyte),
      .raddr_i (rd_word),
      .rdata_o (lane_rd[l])
    );
  end

  word_t mem_word;
  assign mem_word = {lane_rd[0], lane_rd[1], lane_rd[2], lane_rd[3]};

  word_t w_cur, w_new, t1, t2;
  assign w_new = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
  assign w_cur = (rnd_q < 6'd16) ? mem_word : w_new;
  assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + RoundK[rnd_q] + w_cur;
  assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_comb begin
    fill_d = fill_q;
    bits_d = bits_q;
    if (cmd_i.restart) begin
      fill_d = '0;
      bits_d = '0;
    end else if (cmd_i.absorb) begin
      fill_d = fill_q + 6'd1;
      bits_d = bits_q + 64'd8;
    end else if (cmd_i.pad_write) begin
      fill_d = fill_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bits_q <= '0;
      rnd_q  <= '0;
      oidx_q <= '0;
      for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
    end else begin
      fill_q <= fill_d;
      bits_q <= bits_d;
      if (cmd_i.comp_start) begin
        rnd_q <= '0;
      end else if (cmd_i.round_en) begin
        rnd_q <= rnd_q + 6'd1;
      end
      if (cmd_i.out_next) begin
        oidx_q <= oidx_q + 3'd1;
      end
      if (cmd_i.restart) begin
        for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
      end else if (cmd_i.comp_done) begin
        for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.comp_start) begin
      for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
    end else if (cmd_i.round_en) begin
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
      w_q[15] <= w_cur;
    end
  end

  assign stat_o.fill_wrap    = (fill_q == 6'd63);
  assign stat_o.len_zone     = (fill_q >= 6'(LenPos));
  assign stat_o.round_last   = (rnd_q == 6'(Rounds - 1));
  assign stat_o.out_last     = (oidx_q == 3'd7);

  assign digest_word_o = hash_q[oidx_q];
  assign word_index_o  = oidx_q;

endmodule

/* rtl/core/sha256_ctrl.sv */
// Controller state machine of the SHA-256 hasher: handshakes and datapath sequencing.
// Depends on sha256_pkg.
module sha256_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               byte_present_i,
  input  logic               end_of_message_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sha256_pkg::cmd_t   cmd_o,
  input  sha256_pkg::stat_t  stat_i
);
  import sha256_pkg::*;

  state_e state_q, state_d;
  logic   fin_q, fin_d;       // padding pending after this compression
  logic   first_q, first_d;   // next padding byte is 0x80
  logic   lenblk_q, lenblk_d; // the current padding block carries the length
  logic   rwait_q, rwait_d;   // wait for the registered RAM read before rounds
  logic   fold_q, fold_d;     // rounds finished, fold into the hash

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      fin_q    <= 1'b0;
      first_q  <= 1'b0;
      lenblk_q <= 1'b0;
      rwait_q  <= 1'b0;
      fold_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      fin_q    <= fin_d;
      first_q  <= first_d;
      lenblk_q <= lenblk_d;
      rwait_q  <= rwait_d;
      fold_q   <= fold_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    fin_d       = fin_q;
    first_d     = first_q;
    lenblk_d    = lenblk_q;
    rwait_d     = 1'b0;
    fold_d      = 1'b0;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.absorb = byte_present_i;
          fin_d   = end_of_message_i;
          first_d = 1'b1;
          if (byte_present_i && stat_i.fill_wrap) begin
            state_d = StCompress;
            rwait_d = 1'b1;
          end else if (end_of_message_i) begin
            state_d = StPadFill;
          end
        end
      end
      StCompress, StPadComp: begin
        if (rwait_q) begin
          cmd_o.comp_start = 1'b1;
        end else if (fold_q) begin
          cmd_o.comp_done = 1'b1;
          if (state_q == StPadComp) begin
            if (lenblk_q) begin
              state_d = StEmit;
            end else begin
              // The 0x80 block had no room for the length; a second block follows.
              state_d  = StPadFill;
              lenblk_d = 1'b1;
            end
          end else begin
            state_d = fin_q ? StPadFill : StIdle;
          end
        end else begin
          cmd_o.round_en = 1'b1;
          fold_d = stat_i.round_last;
        end
      end
      StPadFill: begin
        cmd_o.pad_write = 1'b1;
        cmd_o.pad_first = first_q;
        cmd_o.pad_len   = lenblk_q && !first_q;
        first_d = 1'b0;
        // The length fits in this block only if the 0x80 lands below it.
        if (first_q) begin
          lenblk_d = !stat_i.len_zone;
        end
        if (stat_i.fill_wrap) begin
          state_d = StPadComp;
          rwait_d = 1'b1;
        end
      end
      StEmit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.out_next = 1'b1;
          if (stat_i.out_last) begin
            cmd_o.restart = 1'b1;
            fin_d   = 1'b0;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

/* rtl/core/sha256_byte_stream_hasher.sv */
// Top level of the SHA-256 byte stream hasher.
// Depends on sha256_pkg, sha256_ctrl and sha256_datapath.

// The hasher takes one message byte per transaction and fills a 64-byte block.
// Completing a block starts the compression, which runs one round per cycle
// through a single shared round unit: a wait for the registered block-RAM read,
// the 64 rounds and a fold of the working variables into the hash, during
// which no input is taken. A transaction with end_of_message set writes the
// padding one byte per cycle from the fill level to the end of the block, runs
// one or two more compressions, and then presents the digest as eight 32-bit
// transactions, word 0 (most significant) first, with last_word on word 7. The
// hash then returns to its initial value and the next message may start.
// Sustained throughput is set by the round unit running 64 rounds per block,
// as no byte is taken while it runs.
module sha256_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  message_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha256_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sha256_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .byte_present_i   (byte_present_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cmd_o            (cmd),
    .stat_i           (stat)
  );

  sha256_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .message_byte_i (message_byte_i),
    .digest_word_o  (digest_word_o),
    .word_index_o   (word_index_o)
  );

  assign last_word_o = (word_index_o == 3'd7);

endmodule

/* rtl/core/sha256_checker.sv */
// Port-level checker for the SHA-256 hasher, bound to the top level.
// Depends only on the top level's ports.
module sha256_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(digest_word_o))
    else $error("digest changed while stalled");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken during digest output");

  a_in_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> !out_valid_o)
    else $error("input accepted while a digest word is offered");

  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_word_o |=> out_valid_o &&
    word_index_o == $past(word_index_o) + 3'd1)
    else $error("digest word order broken");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_word_o |=> in_ready_o && !out_valid_o)
    else $error("not idle after last word");

endmodule

bind sha256_byte_stream_hasher sha256_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .digest_word_o (digest_word_o),
  .word_index_o  (word_index_o),
  .last_word_o   (last_word_o)
);
